// ===== design/sha_pkg.sv =====
// Shared types, constants and round-constant table for the SHA-256 compression core.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    localparam int unsigned WordW = 32;
    localparam int unsigned Rounds = 64;

    typedef enum logic {
        OP_CHAIN = 1'b0,
        OP_MSG   = 1'b1
    } op_t;

    // Entry of the queue between the front and the compression engine
    typedef struct packed {
        logic             is_msg;
        logic [3:0]       idx;
        logic [WordW-1:0] value;
        logic             start;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } eng_state_t;

    function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
        logic [WordW-1:0] k;
        begin
            unique case (i)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = '0;
            endcase
            return k;
        end
    endfunction
endpackage

// ===== design/sha_front.sv =====
// Front end: classifies input items and queues them for the engine.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic [3:0]         word_index,
    input  logic [31:0]        word_value,
    output sha_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  logic               cmd_take
);
    import sha_pkg::*;

    // Two-entry queue
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    logic       acc, drop;
    cmd_t       c_in;

    assign full      = cnt_reg == 2'd2;
    assign acc       = push && !full;
    // Drop chaining writes beyond index 7
    assign drop      = (op_t'(op) == OP_CHAIN) && word_index[3];
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        c_in.is_msg = op;
        c_in.idx    = word_index;
        c_in.value  = word_value;
        c_in.start  = op && (word_index == 4'd15);
    end

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, acc && !drop} - {1'b0, cmd_take && cmd_valid};
    end

    // Hold the queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd_take && cmd_valid)
                rd_reg <= !rd_reg;
            if (acc && !drop)
                wr_reg <= !wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && !drop)
            q_reg[wr_reg] <= c_in;
    end

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue overflow");
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> (cnt_reg <= 2'd1))
        else $error("queue count jumped");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !cmd_take) |=> full)
        else $error("full dropped without transfer");
endmodule

// ===== design/sha_engine.sv =====
// Back end: message buffer, 64-round compression and output of chaining words.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::cmd_t      cmd,
    input  logic               cmd_valid,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         out_index,
    output logic [31:0]        out_value,
    output logic               out_last
);
    import sha_pkg::*;

    eng_state_t state_reg, state_next;
    logic [31:0] hv_reg [8];
    logic [31:0] buf_reg [16];   // message words as written
    logic [31:0] msg_reg [16];   // sliding schedule window
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [5:0]  rnd_reg;
    logic [2:0]  oi_reg;
    logic        outv_reg;
    logic [31:0] w, w_new, t1, t2, s0, s1, x, y;

    function automatic logic [31:0] rr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    assign w     = msg_reg[0];
    assign x     = msg_reg[1];
    assign y     = msg_reg[14];
    assign s0    = rr(x, 7) ^ rr(x, 18) ^ (x >> 3);
    assign s1    = rr(y, 17) ^ rr(y, 19) ^ (y >> 10);
    assign w_new = msg_reg[0] + s0 + msg_reg[9] + s1;
    assign t1    = h_reg + (rr(e_reg, 6) ^ rr(e_reg, 11) ^ rr(e_reg, 25))
                 + ((e_reg & f_reg) ^ (~e_reg & g_reg)) + round_k(rnd_reg) + w;
    assign t2    = (rr(a_reg, 2) ^ rr(a_reg, 13) ^ rr(a_reg, 22))
                 + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (cmd_valid && cmd.start) state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'(Rounds - 1)) state_next = ST_ADD;
            ST_ADD:   state_next = ST_EMIT;
            ST_EMIT:  if (pop && outv_reg && oi_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_take = (state_reg == ST_IDLE) && cmd_valid;
        empty    = !outv_reg;
    end

    assign out_index = oi_reg;
    assign out_value = hv_reg[oi_reg];
    assign out_last  = oi_reg == 3'd7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            oi_reg    <= '0;
            outv_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                hv_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rnd_reg <= '0;
                    if (cmd_take && !cmd.is_msg)
                        hv_reg[cmd.idx[2:0]] <= cmd.value;
                end
                ST_ROUND: rnd_reg <= rnd_reg + 6'd1;
                ST_ADD:
                begin
                    // Feed forward into the chaining value
                    hv_reg[0] <= hv_reg[0] + a_reg; hv_reg[1] <= hv_reg[1] + b_reg;
                    hv_reg[2] <= hv_reg[2] + c_reg; hv_reg[3] <= hv_reg[3] + d_reg;
                    hv_reg[4] <= hv_reg[4] + e_reg; hv_reg[5] <= hv_reg[5] + f_reg;
                    hv_reg[6] <= hv_reg[6] + g_reg; hv_reg[7] <= hv_reg[7] + h_reg;
                    oi_reg   <= '0;
                    outv_reg <= 1'b1;
                end
                ST_EMIT:
                    if (pop && outv_reg)
                    begin
                        oi_reg <= oi_reg + 3'd1;
                        if (oi_reg == 3'd7)
                            outv_reg <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    // Message buffer, window and working variables
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && cmd_take && cmd.is_msg)
        begin
            // Keep the block in the buffer and reload the window from it with the new word
            buf_reg[cmd.idx] <= cmd.value;
            for (int i = 0; i < 16; i++)
                msg_reg[i] <= (4'(i) == cmd.idx) ? cmd.value : buf_reg[i];
            a_reg <= hv_reg[0]; b_reg <= hv_reg[1]; c_reg <= hv_reg[2]; d_reg <= hv_reg[3];
            e_reg <= hv_reg[4]; f_reg <= hv_reg[5]; g_reg <= hv_reg[6]; h_reg <= hv_reg[7];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                msg_reg[i] <= msg_reg[i + 1];
            msg_reg[15] <= w_new;
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        outv_reg |-> state_reg == ST_EMIT)
        else $error("result outside emit");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == ST_IDLE)
        else $error("command taken while busy");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) |-> $past(rnd_reg) == 6'(Rounds - 1))
        else $error("rounds cut short");
endmodule

// ===== design/sha256_block_compress_core.sv =====
// SHA-256 compression core: front queue plus compression engine.
// Word 15 starts the rounds and the feed-forward add, then 8 results are emitted.
// Throughput: one round per cycle in the shared round unit; the engine takes no new
// words from the queue until all results of the block have been popped.
// Reset: asynchronous active-low; clears chaining value and control, not the buffer.
// Depends on sha_pkg, sha_front, sha_engine.
`timescale 1ns / 1ps
module sha256_block_compress_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [3:0]  word_index,
    input  logic [31:0] word_value,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  out_index,
    output logic [31:0] out_value,
    output logic        out_last
);
    import sha_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .word_index(word_index), .word_value(word_value),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .empty(empty), .pop(pop), .out_index(out_index), .out_value(out_value),
        .out_last(out_last)
    );
endmodule
